FILE: rtl/h264dp_pkg.sv
// Shared types and constants for the RTP H.264 depacketizer.
`timescale 1ns / 1ps
package h264dp_pkg;

  // Nonzero NAL unit types below this limit are single NAL unit packets
  localparam logic [4:0] TYPE_AGG_LIMIT = 5'd24;
  localparam logic [4:0] TYPE_FU_A      = 5'd28;

  // Final byte of the 00 00 00 01 start code
  localparam logic [7:0] START_CODE_LAST = 8'h01;
  localparam logic [7:0] START_CODE_ZERO = 8'h00;

  // Start code bytes sent before a command's own byte
  localparam logic [2:0] SC_STEPS = 3'd4;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Saturation point of the byte position
  localparam logic [1:0] POS_SAT = 2'd2;

  typedef enum logic [1:0] {
    KIND_DROP      = 2'd0,
    KIND_SINGLE    = 2'd1,
    KIND_FU        = 2'd2,
    KIND_FU_MARKED = 2'd3
  } kind_t;

  // One queued command: optional start code, then one result
  typedef struct packed {
    logic       sc;    // send start code first
    logic       has;   // result carries a byte
    logic [7:0] data;  // byte to send (zero for a marker-only result)
    logic       eou;   // result ends the access unit
  } cmd_t;

endpackage

FILE: rtl/h264dp_front.sv
// Front end: classifies payload bytes and builds output commands.
`timescale 1ns / 1ps
module h264dp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_byte,
  input  logic               in_last_byte,
  input  logic               in_marker,
  input  logic               q_full,
  output logic               q_push,
  output h264dp_pkg::cmd_t   q_cmd
);
  import h264dp_pkg::*;

  kind_t      kind_r, kind_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [2:0] fhb_r, fhb_nxt;
  logic [1:0] pos_cur;
  logic [4:0] nal_type;
  logic       accept;
  logic       produce;

  assign nal_type = in_data_byte[4:0];
  assign pos_cur  = in_first_byte ? 2'd0 : pos_r;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next state
  always_comb begin
    kind_nxt = kind_r;
    fhb_nxt  = fhb_r;
    if (in_first_byte) begin
      if (nal_type != 5'd0 && nal_type < TYPE_AGG_LIMIT) begin
        kind_nxt = KIND_SINGLE;
      end else if (nal_type == TYPE_FU_A) begin
        if (in_marker) begin
          kind_nxt = KIND_FU_MARKED;
        end else begin
          kind_nxt = KIND_FU;
          fhb_nxt  = in_data_byte[7:5];
        end
      end else begin
        kind_nxt = KIND_DROP;
      end
    end
    pos_nxt = (pos_cur < POS_SAT) ? pos_cur + 2'd1 : POS_SAT;
    if (in_last_byte) begin
      kind_nxt = KIND_DROP;
      pos_nxt  = 2'd0;
    end
  end

  // Command for this byte
  always_comb begin
    q_cmd = '0;
    if (in_first_byte) begin
      if (nal_type != 5'd0 && nal_type < TYPE_AGG_LIMIT) begin
        q_cmd.sc   = 1'b1;
        q_cmd.has  = 1'b1;
        q_cmd.data = in_data_byte;
      end
    end else begin
      unique case (kind_r)
        KIND_SINGLE: begin
          q_cmd.has  = 1'b1;
          q_cmd.data = in_data_byte;
        end
        KIND_FU: begin
          if (pos_cur == 2'd1) begin
            // FU header: start bit rebuilds the NAL header, else strip
            if (in_data_byte[7]) begin
              q_cmd.sc   = 1'b1;
              q_cmd.has  = 1'b1;
              q_cmd.data = {fhb_r, in_data_byte[4:0]};
            end
          end else begin
            q_cmd.has  = 1'b1;
            q_cmd.data = in_data_byte;
          end
        end
        KIND_FU_MARKED: begin
          if (pos_cur >= POS_SAT) begin
            q_cmd.has  = 1'b1;
            q_cmd.data = in_data_byte;
          end
        end
        KIND_DROP: begin
        end
        default: begin
        end
      endcase
    end
    q_cmd.eou = in_last_byte && in_marker;
  end

  assign produce = q_cmd.has || q_cmd.eou;
  assign q_push  = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_DROP;
      pos_r  <= 2'd0;
      fhb_r  <= 3'd0;
    end else if (accept) begin
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
      fhb_r  <= fhb_nxt;
    end
  end

endmodule

FILE: rtl/h264dp_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module h264dp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  h264dp_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output h264dp_pkg::cmd_t head_cmd
);
  import h264dp_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/h264dp_back.sv
// Back end: expands commands into stream bytes behind an output register.
`timescale 1ns / 1ps
module h264dp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  h264dp_pkg::cmd_t head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_end_of_unit
);
  import h264dp_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       ohas_r, ohas_nxt;
  logic       oeou_r, oeou_nxt;
  logic       load;
  logic       in_sc;

  assign load  = head_valid && (!ovalid_r || out_ready);
  assign in_sc = head_cmd.sc && (step_r != SC_STEPS);

  always_comb begin
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    ohas_nxt   = ohas_r;
    oeou_nxt   = oeou_r;
    pop        = 1'b0;
    if (load) begin
      ovalid_nxt = 1'b1;
      if (in_sc) begin
        // Walk the start code, then send the command's byte
        obyte_nxt = (step_r == SC_STEPS - 3'd1) ? START_CODE_LAST : START_CODE_ZERO;
        ohas_nxt  = 1'b1;
        oeou_nxt  = 1'b0;
        step_nxt  = step_r + 3'd1;
      end else begin
        obyte_nxt = head_cmd.data;
        ohas_nxt  = head_cmd.has;
        oeou_nxt  = head_cmd.eou;
        step_nxt  = 3'd0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    ohas_r  <= ohas_nxt;
    oeou_r  <= oeou_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_has_byte    = ohas_r;
  assign out_end_of_unit = oeou_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= SC_STEPS)
    else $error("start code step out of range");

  a_step_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 3'd0) |-> (head_valid && head_cmd.sc))
    else $error("start code in flight without its command");

  a_marker_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ohas_r) |-> (oeou_r && obyte_r == 8'h00))
    else $error("empty result that does not end an access unit");

endmodule

FILE: rtl/h264_rtp_payload_depacketizer.sv
// Top level of the RTP H.264 payload depacketizer.
//
// Takes RTP payload bytes on the in_ channel, one per transfer, with flags
// for the first and last byte of a packet and the packet's RTP marker.
// Emits an Annex B byte stream on the out_ channel: single NAL unit packets
// and FU-A fragments are rebuilt with 00 00 00 01 start codes, other packet
// types are dropped. out_end_of_unit marks the last result of a marker
// packet; out_has_byte low flags a marker-only result with no data.
// The results of a byte pass through the command queue and the output
// register before they are offered. Plain payload bytes go in at one input
// byte per cycle while the queue has room; a byte that opens a NAL unit
// yields five results, so the output port, one result per cycle while the
// receiver is ready, sets the rate over those bursts. A four-entry command
// queue parts the classifier from the output sequencer, so input keeps
// flowing during start codes. in_ready drops only when that queue is full.
// When the receiver stalls, the output register holds its result and the
// queue fills; then input stalls. Reset (synchronous, active low) empties
// the queue, clears the output register and forgets any packet in progress.
`timescale 1ns / 1ps
module h264_rtp_payload_depacketizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  input  logic       in_marker,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_unit
);
  import h264dp_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  h264dp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .in_marker     (in_marker),
    .q_full        (full),
    .q_push        (push),
    .q_cmd         (push_cmd)
  );

  h264dp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  h264dp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_end_of_unit (out_end_of_unit)
  );

endmodule

FILE: bench/tb_h264_rtp_payload_depacketizer.sv
// Self-checking testbench for the RTP H.264 payload depacketizer.
`timescale 1ns / 1ps
module tb_h264_rtp_payload_depacketizer;
  import h264dp_pkg::*;

  localparam int IDLE_PCT    = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_BYTES  = 80;
  localparam int N_DIRECTED  = 25;

  // How a stimulus row gets its expected results
  typedef enum logic [1:0] {
    CHK_PREDICT = 2'd0,  // from the predictor
    CHK_NOTHING = 2'd1,  // no result at all
    CHK_ONE     = 2'd2   // exactly the one result typed in the row
  } chk_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       marker;
    chk_t       chk;
    logic [7:0] x_byte;
    logic       x_has;
    logic       x_eou;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eou;
  } result_t;

  // data, first, last, marker, check, expected byte, has, end of unit
  localparam stim_t DIRECTED [N_DIRECTED] = '{
    // stray byte after reset carrying last and marker: marker-only result
    '{8'hFF, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'h00, 1'b0, 1'b1},
    '{8'h00, 1'b0, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    // type 0 is dropped, its marker end still yields a marker-only result
    '{8'h00, 1'b1, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'h00, 1'b0, 1'b1},
    // single NAL unit
    '{8'h65, 1'b1, 1'b0, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'hFF, 1'b1, 1'b1},
    // type 23, one-byte packet
    '{8'hF7, 1'b1, 1'b1, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    // type 24 is dropped
    '{8'h18, 1'b1, 1'b0, 1'b1, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h5A, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'h00, 1'b0, 1'b1},
    // FU-A start fragment, marker clear at first byte, set at last byte
    '{8'h7C, 1'b1, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h85, 1'b0, 1'b0, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    '{8'hAB, 1'b0, 1'b0, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    '{8'hCD, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'hCD, 1'b1, 1'b1},
    // FU-A continuation fragment with F set
    '{8'hFC, 1'b1, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h11, 1'b0, 1'b1, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    // FU-A with marker: both headers stripped
    '{8'h5C, 1'b1, 1'b0, 1'b1, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h85, 1'b0, 1'b0, 1'b1, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h99, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'h99, 1'b1, 1'b1},
    // short marked FU-A, ends inside its headers
    '{8'h7C, 1'b1, 1'b0, 1'b1, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h85, 1'b0, 1'b1, 1'b1, CHK_ONE,     8'h00, 1'b0, 1'b1},
    // first flag inside a packet restarts it as FU-A
    '{8'h61, 1'b1, 1'b0, 1'b0, CHK_PREDICT, 8'h00, 1'b0, 1'b0},
    '{8'h7C, 1'b1, 1'b0, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0},
    '{8'h1F, 1'b0, 1'b1, 1'b0, CHK_NOTHING, 8'h00, 1'b0, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_last_byte = 1'b0;
  logic       in_marker = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_end_of_unit;

  // Shadow state of the depacketizer
  logic [1:0] pred_pos;
  kind_t      pred_kind;
  logic [2:0] pred_fhdr;

  result_t    burst[$];
  result_t    stream_expected[$];
  int         mismatches = 0;
  int         payload_sent = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  logic       hold_used = 1'b0;
  logic       hold_armed = 1'b0;
  logic       calm = 1'b0;

  h264_rtp_payload_depacketizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .in_last_byte    (in_last_byte),
    .in_marker       (in_marker),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_end_of_unit (out_end_of_unit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit(input logic [7:0] b);
    burst.push_back('{b, 1'b1, 1'b0});
  endfunction

  function automatic void emit_start_code();
    emit(START_CODE_ZERO);
    emit(START_CODE_ZERO);
    emit(START_CODE_ZERO);
    emit(START_CODE_LAST);
  endfunction

  // Work out the stream bytes that one payload byte yields
  function automatic void depacketize_byte(input stim_t s);
    logic [4:0] nal_type;
    logic [1:0] pos;
    result_t    tail;
    burst.delete();
    nal_type = s.data[4:0];
    if (s.first) begin
      pos = 2'd0;
      if (nal_type != 5'd0 && nal_type < TYPE_AGG_LIMIT) begin
        pred_kind = KIND_SINGLE;
        emit_start_code();
        emit(s.data);
      end else if (nal_type == TYPE_FU_A) begin
        if (s.marker) begin
          pred_kind = KIND_FU_MARKED;
        end else begin
          pred_kind = KIND_FU;
          pred_fhdr = s.data[7:5];
        end
      end else begin
        pred_kind = KIND_DROP;
      end
    end else begin
      pos = pred_pos;
      case (pred_kind)
        KIND_SINGLE: emit(s.data);
        KIND_FU: begin
          if (pos == 2'd1) begin
            // FU header: rebuild the NAL header only on the start bit
            if (s.data[7]) begin
              emit_start_code();
              emit({pred_fhdr, s.data[4:0]});
            end
          end else begin
            emit(s.data);
          end
        end
        KIND_FU_MARKED: if (pos >= POS_SAT) emit(s.data);
        default: ;
      endcase
    end
    pred_pos = (pos < POS_SAT) ? pos + 2'd1 : POS_SAT;
    if (s.last) begin
      if (s.marker) begin
        if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0});
        tail = burst.pop_back();
        tail.eou = 1'b1;
        burst.push_back(tail);
      end
      pred_kind = KIND_DROP;
      pred_pos = 2'd0;
    end
  endfunction

  // Offer one byte, wait for its transfer, then book its expected results
  task automatic send_byte(input stim_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= s.data;
    in_first_byte <= s.first;
    in_last_byte  <= s.last;
    in_marker     <= s.marker;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    depacketize_byte(s);
    case (s.chk)
      CHK_PREDICT: foreach (burst[k]) stream_expected.push_back(burst[k]);
      CHK_ONE:     stream_expected.push_back('{s.x_byte, s.x_has, s.x_eou});
      default: ;
    endcase
  endtask

  // One random packet, mostly well formed; some noise and truncation
  task automatic send_packet();
    int         style;
    int         len;
    int         nt;
    logic       mk;
    logic       cut;
    stim_t      s;
    style = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
    mk = ($urandom_range(3) == 0) || (style >= 70 && style < 82);
    cut = ($urandom_range(19) == 0);
    s = '0;
    s.chk = CHK_PREDICT;
    if (style >= 92) begin
      // stray bytes between packets
      repeat ($urandom_range(3, 1)) begin
        s.data   = 8'($urandom);
        s.last   = 1'($urandom_range(1));
        s.marker = 1'($urandom_range(1));
        send_byte(s);
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        s.data   = 8'($urandom);
        s.first  = (i == 0);
        s.last   = (i == len - 1) && !cut;
        s.marker = mk;
        if (i == 0) begin
          if (style < 30) begin
            s.data[4:0] = 5'($urandom_range(23, 1));
          end else if (style < 82) begin
            s.data[4:0] = TYPE_FU_A;
          end else begin
            do nt = $urandom_range(31); while ((nt >= 1 && nt < 24) || nt == 28);
            s.data[4:0] = nt[4:0];
          end
          // occasionally disagree with the marker of the last byte
          if ($urandom_range(9) == 0) s.marker = !mk;
        end
        if (i == 1 && style >= 30 && style < 55) s.data[7] = 1'b1;
        if (i == 1 && style >= 55 && style < 70) s.data[7] = 1'b0;
        send_byte(s);
        payload_sent++;
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off, calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stream_expected.size() == 0) begin
        $display("%0t: unexpected result byte=%h has=%b eou=%b", $time,
                 out_byte, out_has_byte, out_end_of_unit);
        mismatches++;
      end else begin
        want = stream_expected.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
          mismatches++;
        end
        if (out_has_byte !== want.has) begin
          $display("%0t: out_has_byte expected %b actual %b", $time,
                   want.has, out_has_byte);
          mismatches++;
        end
        if (out_end_of_unit !== want.eou) begin
          $display("%0t: out_end_of_unit expected %b actual %b", $time,
                   want.eou, out_end_of_unit);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pred_pos  = 2'd0;
    pred_kind = KIND_DROP;
    pred_fhdr = 3'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) send_byte(DIRECTED[r]);

    while (payload_sent < RAND_BYTES) begin
      calm       <= (payload_sent >= 10 && payload_sent < 40);
      hold_armed <= (payload_sent >= 45);
      send_packet();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (stream_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && stream_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/h264dp_pkg.sv
rtl/h264dp_front.sv
rtl/h264dp_queue.sv
rtl/h264dp_back.sv
rtl/h264_rtp_payload_depacketizer.sv
bench/tb_h264_rtp_payload_depacketizer.sv
